### design/mexp_pkg.sv
package mexp_pkg;

  localparam int unsigned ElemBits = 32;
  localparam int unsigned ExpBits  = 32;
  localparam int unsigned CntBits  = 6;

  localparam logic [ElemBits-1:0] ModulusReset = 32'd4293918721;

  typedef logic [ElemBits-1:0] elem_t;

  typedef struct packed {
    logic  start;
    elem_t a;
    elem_t b;
    elem_t m;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    elem_t prod;
  } mul_rsp_t;

endpackage

### design/mexp_mulmod.sv
module mexp_mulmod (
  input  logic               clk,
  input  logic               rst_n,
  input  mexp_pkg::mul_req_t req,
  output mexp_pkg::mul_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic [mexp_pkg::CntBits-1:0]  cnt_r, cnt_nxt;
  mexp_pkg::elem_t               a_r, a_nxt, b_r, b_nxt, m_r, m_nxt, acc_r, acc_nxt;
  logic                          done_r, done_nxt;

  logic [mexp_pkg::ElemBits:0]   dbl, sum;
  mexp_pkg::elem_t               acc2;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    // double and add, one multiplier bit per cycle from the top
    dbl = {1'b0, acc_r} + {1'b0, acc_r};
    if (dbl >= {1'b0, m_r}) dbl = dbl - {1'b0, m_r};
    acc2 = dbl[mexp_pkg::ElemBits-1:0];
    sum  = {1'b0, acc2} + {1'b0, a_r};
    if (sum >= {1'b0, m_r}) sum = sum - {1'b0, m_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      m_nxt    = req.m;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = b_r[mexp_pkg::ElemBits-1] ? sum[mexp_pkg::ElemBits-1:0] : acc2;
      b_nxt   = {b_r[mexp_pkg::ElemBits-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mexp_pkg::CntBits'(mexp_pkg::ElemBits - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### design/mexp_divu.sv
module mexp_divu (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  mexp_pkg::elem_t num,
  input  mexp_pkg::elem_t den,
  output logic            done,
  output mexp_pkg::elem_t quo,
  output mexp_pkg::elem_t rem
);

  logic                          busy_r, busy_nxt, done_r, done_nxt;
  logic [mexp_pkg::CntBits-1:0]  cnt_r, cnt_nxt;
  mexp_pkg::elem_t               q_r, q_nxt, d_r, d_nxt, r_r, r_nxt;
  logic [mexp_pkg::ElemBits:0]   sh, diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    sh       = {r_r, q_r[mexp_pkg::ElemBits-1]};
    diff     = sh - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = num;
      d_nxt    = den;
      r_nxt    = '0;
    end else if (busy_r) begin
      // restoring division, one quotient bit per cycle
      if (sh >= {1'b0, d_r}) begin
        r_nxt = diff[mexp_pkg::ElemBits-1:0];
        q_nxt = {q_r[mexp_pkg::ElemBits-2:0], 1'b1};
      end else begin
        r_nxt = sh[mexp_pkg::ElemBits-1:0];
        q_nxt = {q_r[mexp_pkg::ElemBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mexp_pkg::CntBits'(mexp_pkg::ElemBits - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    d_r <= d_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

### design/modular_exponentiation_with_inverse.sv
// Modular exponentiation with optional inverse, one word at a time.
// Input channel: in_valid/in_stall with in_base_value and signed in_exponent.
// Output channel: out_valid/out_stall with out_power = base^exponent mod
// modulus. A negative exponent first inverts the base by extended Euclid.
// Config channel: cfg_valid/cfg_ready/cfg_data writes the modulus; write it
// only while the block is idle. Reset loads modulus 4293918721.
// Steps: the base is reduced by the bit-serial divider. Each of the 32
// exponent rounds runs two double-and-add multiplies on one shared
// multiplier. An inversion adds one multiply and one divide per Euclid step.
// One word is in flight at a time; in_stall is high while busy.
// When the receiver stalls, out_power holds until taken; the next word is
// not accepted until then. Reset (rst_n low, synchronous) drops any word in
// flight and leaves the block idle.
module modular_exponentiation_with_inverse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_base_value,
  input  logic signed [31:0]  in_exponent,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_power,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RED    = 4'd1;
  localparam logic [3:0] S_EDIV   = 4'd2;
  localparam logic [3:0] S_EMUL   = 4'd3;
  localparam logic [3:0] S_EDONE  = 4'd4;
  localparam logic [3:0] S_PMUL   = 4'd5;
  localparam logic [3:0] S_PSQR   = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_ESTART = 4'd8;

  logic [3:0]                   st_r, st_nxt;
  mexp_pkg::elem_t              mod_r, mod_nxt;
  mexp_pkg::elem_t              base_r, base_nxt, res_r, res_nxt, mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  logic [mexp_pkg::CntBits-1:0] rnd_r, rnd_nxt;
  mexp_pkg::elem_t              cp_r, cp_nxt, cc_r, cc_nxt, rc_r, rc_nxt, rn_r, rn_nxt;
  mexp_pkg::elem_t              q_r, q_nxt;

  mexp_pkg::mul_req_t mreq;
  mexp_pkg::mul_rsp_t mrsp;
  logic               dstart, ddone;
  mexp_pkg::elem_t    dnum, dden, dquo, drem;
  mexp_pkg::elem_t    qm, subv;
  mexp_pkg::elem_t    mag_in;

  mexp_mulmod u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  mexp_divu   u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum),
                     .den(dden), .done(ddone), .quo(dquo), .rem(drem));

  assign in_stall  = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_power = res_r;

  // q mod m: the quotient never exceeds m, so one conditional subtract suffices
  assign qm     = (q_r >= mod_r) ? q_r - mod_r : q_r;
  assign subv   = (cp_r >= mrsp.prod) ? cp_r - mrsp.prod : cp_r + (mod_r - mrsp.prod);
  assign mag_in = in_exponent[31] ? 32'(0) - 32'(in_exponent) : 32'(in_exponent);

  always_comb begin
    st_nxt   = st_r;
    mod_nxt  = mod_r;
    base_nxt = base_r;
    res_nxt  = res_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    rnd_nxt  = rnd_r;
    cp_nxt   = cp_r;
    cc_nxt   = cc_r;
    rc_nxt   = rc_r;
    rn_nxt   = rn_r;
    q_nxt    = q_r;
    mreq     = '{start: 1'b0, a: res_r, b: base_r, m: mod_r};
    dstart   = 1'b0;
    dnum     = base_r;
    dden     = mod_r;
    case (st_r)
      S_IDLE: begin
        if (cfg_valid) mod_nxt = cfg_data;
        if (in_valid) begin
          base_nxt = in_base_value;
          mag_nxt  = mag_in;
          neg_nxt  = in_exponent[31];
          rnd_nxt  = '0;
          if (mod_r < 32'd2) begin
            res_nxt = '0;
            st_nxt  = S_OUT;
          end else begin
            dnum   = in_base_value;
            dstart = 1'b1;
            st_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (ddone) begin
          base_nxt = drem;
          res_nxt  = 32'd1;
          if (neg_r) begin
            cp_nxt = '0;
            cc_nxt = 32'd1;
            rc_nxt = drem;
            rn_nxt = mod_r;
            q_nxt  = '0;
            st_nxt = S_ESTART;
          end else begin
            st_nxt = S_PMUL;
            mreq   = '{start: 1'b1, a: 32'd1, b: drem, m: mod_r};
          end
        end
      end
      S_ESTART: begin
        if (rn_r == '0) begin
          base_nxt = (cc_r >= mod_r) ? cc_r - mod_r : cc_r;
          st_nxt   = S_PMUL;
          mreq     = '{start: 1'b1, a: res_r, b: base_nxt, m: mod_r};
        end else begin
          mreq   = '{start: 1'b1, a: qm, b: cc_r, m: mod_r};
          st_nxt = S_EMUL;
        end
      end
      S_EMUL: begin
        if (mrsp.done) begin
          cp_nxt = cc_r;
          cc_nxt = subv;
          rc_nxt = rn_r;
          dstart = 1'b1;
          dnum   = rc_r;
          dden   = rn_r;
          st_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        if (ddone) begin
          q_nxt  = dquo;
          rn_nxt = drem;
          st_nxt = S_ESTART;
        end
      end
      S_PMUL: begin
        if (mrsp.done) begin
          if (mag_r[0]) res_nxt = mrsp.prod;
          mreq   = '{start: 1'b1, a: base_r, b: base_r, m: mod_r};
          st_nxt = S_PSQR;
        end
      end
      S_PSQR: begin
        if (mrsp.done) begin
          base_nxt = mrsp.prod;
          mag_nxt  = {1'b0, mag_r[31:1]};
          rnd_nxt  = rnd_r + 1'b1;
          if (rnd_r == mexp_pkg::CntBits'(mexp_pkg::ExpBits - 1)) begin
            st_nxt = S_OUT;
          end else begin
            mreq   = '{start: 1'b1, a: res_r, b: mrsp.prod, m: mod_r};
            st_nxt = S_PMUL;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      mod_r <= mexp_pkg::ModulusReset;
    end else begin
      st_r  <= st_nxt;
      mod_r <= mod_nxt;
    end
    base_r <= base_nxt;
    res_r  <= res_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    rnd_r  <= rnd_nxt;
    cp_r   <= cp_nxt;
    cc_r   <= cc_nxt;
    rc_r   <= rc_nxt;
    rn_r   <= rn_nxt;
    q_r    <= q_nxt;
  end

endmodule

### sim/modular_exponentiation_with_inverse_tb.sv
module modular_exponentiation_with_inverse_tb;

  typedef struct packed {
    mexp_pkg::elem_t    base;
    logic signed [31:0] expo;
  } word_t;

  localparam int WatchdogLimit = 40000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_base_value;
  logic signed [31:0] in_exponent;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        out_power;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;

  word_t           pending_words[$];
  mexp_pkg::elem_t expected_powers[$];
  mexp_pkg::elem_t field_modulus;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              mismatches;
  int              idle_cycles;
  logic            in_took;

  modular_exponentiation_with_inverse DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_base_value(in_base_value),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_power    (out_power),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // base^expo mod m; a negative exponent inverts the base by extended Euclid
  function automatic mexp_pkg::elem_t modpow(mexp_pkg::elem_t b, logic [31:0] e,
                                             mexp_pkg::elem_t m);
    longint unsigned mm, acc, sq, cp, cc, cn, rc, rn, ro, q, t;
    logic [31:0] mag;
    mm = m;
    if (mm < 2) return '0;
    sq = b % mm;
    mag = e[31] ? (32'd0 - e) : e;
    if (e[31]) begin
      cp = 0; cc = 1; rc = sq; rn = mm; q = 0;
      while (rn != 0) begin
        ro = rc;
        t = ((q % mm) * cc) % mm;
        cn = (cp >= t) ? cp - t : cp + (mm - t);
        cp = cc;
        cc = cn;
        rc = rn;
        q = ro / rc;
        rn = ro - q * rc;
      end
      sq = cc % mm;
    end
    acc = 1 % mm;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return mexp_pkg::elem_t'(acc);
  endfunction

  // driver: present words at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        word_t w;
        w = pending_words.pop_front();
        in_valid      <= 1'b1;
        in_base_value <= w.base;
        in_exponent   <= w.expo;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: predict on accept, check results, watchdog
  always @(posedge clk) begin
    mexp_pkg::elem_t exp_p;
    logic            any;
    if (!rst_n) begin
      in_took <= 1'b0;
      idle_cycles <= 0;
    end else begin
      any = 1'b0;
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_powers = {expected_powers,
                           modpow(in_base_value, in_exponent, field_modulus)};
        any = 1'b1;
      end
      if (out_valid && !out_stall) begin
        any = 1'b1;
        if (expected_powers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: power=%0d", out_power);
        end else begin
          exp_p = expected_powers.pop_front();
          if (exp_p !== out_power) begin
            mismatches++;
            if (mismatches <= 10)
              $display("power mismatch: expected %0d got %0d", exp_p, out_power);
          end
        end
      end
      if (cfg_valid && cfg_ready) any = 1'b1;
      idle_cycles <= any ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic add_word(mexp_pkg::elem_t b, logic signed [31:0] e);
    word_t w;
    w.base = b;
    w.expo = e;
    pending_words = {pending_words, w};
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_powers.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_modulus(mexp_pkg::elem_t v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    field_modulus = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random_words(int n);
    mexp_pkg::elem_t    b;
    logic signed [31:0] e;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(5))
        0: b = $urandom_range(3);
        1: b = field_modulus - $urandom_range(2);
        2: b = field_modulus + $urandom_range(2);
        default: b = $urandom;
      endcase
      case ($urandom_range(3))
        0: e = $signed($urandom_range(20)) - 10;
        default: begin
          e = $urandom;
          if (e == 32'sh8000_0000) e = 32'sh7fff_ffff;
        end
      endcase
      add_word(b, e);
    end
  endtask

  initial begin
    mexp_pkg::elem_t moduli[6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_base_value = '0;
    in_exponent = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    field_modulus = mexp_pkg::ModulusReset;
    send_idle_pct = 10;
    recv_stall_pct = 78;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset modulus
    add_word(32'd0, 32'sd0);
    add_word(32'd0, 32'sd5);
    add_word(32'd0, -32'sd1);
    add_word(32'd1, 32'sd0);
    add_word(32'd2, 32'sd10);
    add_word(32'd2, -32'sd1);
    add_word(32'd3, -32'sd7);
    add_word(mexp_pkg::ModulusReset, 32'sd3);
    add_word(mexp_pkg::ModulusReset, -32'sd3);
    add_word(mexp_pkg::ModulusReset - 1, -32'sd1);
    add_word(mexp_pkg::ModulusReset + 5, 32'sd2);
    add_word(32'hffff_ffff, 32'sh7fff_ffff);
    add_word(32'hffff_ffff, -32'sh7fff_ffff);
    add_word(32'h1234_5678, 32'sh5555_5555);
    add_word(32'h8765_4321, -32'sh2aaa_aaaa);
    add_word(32'd7, -32'sd2);
    add_word(32'hdead_beef, 32'sd1);
    add_word(32'hdead_beef, -32'sd1);
    drain();

    moduli = '{mexp_pkg::ModulusReset, 32'd3, 32'hffff_ffff, 32'd4294967291, 32'd65537,
                32'd1000};
    for (int p = 0; p < 6; p++) begin
      send_idle_pct  = (p < 2) ? 10 : (p < 4) ? 78 : 0;
      recv_stall_pct = (p < 2) ? 78 : (p < 4) ? 10 : 0;
      write_modulus(moduli[p]);
      if (moduli[p] == 32'd3) begin
        add_word(32'd3, -32'sd1);
        add_word(32'd2, -32'sd1);
        add_word(32'hffff_ffff, 32'sd9);
      end
      add_random_words(72);
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
